>>> hw/rtl/rmfb_pkg.sv
`default_nettype none

package rmfb_pkg;

  localparam int unsigned POS_W  = 12;
  localparam int unsigned CRD_W  = 11;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ROT_W  = 2;

  // stream packing
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned OUT_USER_W = 1;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_ROTATION = 1'b0;  // selected by paddr[2]

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  localparam logic [BYTE_W-1:0] FILL_WHITE = 8'hFF;
  localparam logic [BYTE_W-1:0] FILL_BLACK = 8'h00;
  localparam logic [BYTE_W-1:0] MSB_MASK   = 8'h80;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    RES_DONE = 2'd0,
    RES_FAIL = 2'd1,
    RES_BYTE = 2'd2
  } res_e;

  typedef struct packed {
    logic load_item;
    logic map_step;
    logic addr_step;
    logic sweep_start;
    logic sweep_step;
    logic rd_pixel;
    logic rd_byte;
    logic wr_pixel;
    logic res_load;
    res_e res_kind;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic clipped;
    logic rd_ok;
    logic sweep_last;
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rmfb_ram.sv
`default_nettype none

module rmfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 48000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/rmfb_ctrl.sv
`default_nettype none

module rmfb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire rmfb_pkg::stat_t stat_i,
  output rmfb_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DECODE,
    ST_MAP,
    ST_ADDR,
    ST_RD_PIX,
    ST_MODIFY,
    ST_RD_BYTE,
    ST_CAPTURE,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   sweep_rst_q, sweep_rst_d;  // sweep after reset ends without a result

  always_comb begin
    state_d          = state_q;
    sweep_rst_d      = sweep_rst_q;
    cmd_o            = '0;
    cmd_o.res_kind   = rmfb_pkg::RES_DONE;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          if (sweep_rst_q) begin
            sweep_rst_d = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            cmd_o.res_load = 1'b1;
            state_d        = ST_RESULT;
          end
        end
      end
      ST_IDLE: begin
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.req)
          rmfb_pkg::REQ_PIXEL: begin
            state_d = ST_MAP;
          end
          rmfb_pkg::REQ_CLEAR: begin
            cmd_o.sweep_start = 1'b1;
            state_d           = ST_SWEEP;
          end
          rmfb_pkg::REQ_READ: begin
            if (stat_i.rd_ok) begin
              state_d = ST_RD_BYTE;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = rmfb_pkg::RES_FAIL;
              state_d        = ST_RESULT;
            end
          end
          default: begin
            cmd_o.res_load = 1'b1;
            state_d        = ST_RESULT;
          end
        endcase
      end
      ST_MAP: begin
        cmd_o.map_step = 1'b1;
        state_d        = ST_ADDR;
      end
      ST_ADDR: begin
        if (stat_i.clipped) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = rmfb_pkg::RES_FAIL;
          state_d        = ST_RESULT;
        end else begin
          cmd_o.addr_step = 1'b1;
          state_d         = ST_RD_PIX;
        end
      end
      ST_RD_PIX: begin
        cmd_o.rd_pixel = 1'b1;
        state_d        = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd_o.wr_pixel = 1'b1;
        cmd_o.res_load = 1'b1;
        state_d        = ST_RESULT;
      end
      ST_RD_BYTE: begin
        cmd_o.rd_byte = 1'b1;
        state_d       = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = rmfb_pkg::RES_BYTE;
        state_d        = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_rst_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      sweep_rst_q <= sweep_rst_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESULT);

endmodule

`default_nettype wire

>>> hw/rtl/rmfb_dpath.sv
`default_nettype none

module rmfb_dpath #(
  parameter int unsigned PANEL_WIDTH  = 800,
  parameter int unsigned PANEL_HEIGHT = 480
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [rmfb_pkg::IN_DATA_W-1:0]    in_data_i,
  input  wire logic [rmfb_pkg::IN_USER_W-1:0]    in_user_i,
  input  wire logic [rmfb_pkg::ROT_W-1:0]        rotation_i,
  input  wire rmfb_pkg::cmd_t                    cmd_i,
  output rmfb_pkg::stat_t                        stat_o,
  output logic      [rmfb_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic      [rmfb_pkg::OUT_USER_W-1:0]   out_user_o
);

  localparam int unsigned STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
  localparam int unsigned AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned PIX_RAW     = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
  localparam int unsigned PIX_W       = (PIX_RAW > 4) ? PIX_RAW : 4;
  // logical size may reach 2048, one bit above a coordinate
  localparam int unsigned LIM_W       = rmfb_pkg::POS_W + 1;

  localparam logic [LIM_W-1:0]           LW_ROT0 = LIM_W'(PANEL_WIDTH);
  localparam logic [LIM_W-1:0]           LH_ROT0 = LIM_W'(PANEL_HEIGHT);
  localparam logic [rmfb_pkg::CRD_W-1:0] PW_M1   = rmfb_pkg::CRD_W'(PANEL_WIDTH - 1);
  localparam logic [rmfb_pkg::CRD_W-1:0] PH_M1   = rmfb_pkg::CRD_W'(PANEL_HEIGHT - 1);
  localparam logic [PIX_W-1:0]           PW_PIX  = PIX_W'(PANEL_WIDTH);
  localparam logic [AW-1:0]              LAST_A  = AW'(STORE_BYTES - 1);

  // latched item
  rmfb_pkg::req_e                 req_q;
  logic [rmfb_pkg::POS_W-1:0]     x_q, y_q;
  logic                           black_q;
  logic [rmfb_pkg::IDX_W-1:0]     bidx_q;

  // pixel path
  logic [rmfb_pkg::CRD_W-1:0]     px_q, px_d, py_q, py_d;
  logic                           clip_q, clip_d;
  logic [AW-1:0]                  paddr_q, paddr_d;
  logic [2:0]                     bit_q;
  logic [PIX_W-1:0]               pix;

  // fill sweep
  logic [AW-1:0]                  cnt_q;
  logic [rmfb_pkg::BYTE_W-1:0]    fill_q;

  // result
  logic [rmfb_pkg::BYTE_W-1:0]    rbyte_q;
  logic                           rstat_q;

  logic [rmfb_pkg::CRD_W-1:0]     x_lo, y_lo;
  logic [LIM_W-1:0]               lw, lh;
  logic [31:0]                    bidx_ext;
  logic [AW-1:0]                  bidx_a;
  logic [rmfb_pkg::BYTE_W-1:0]    mask, rdata, wdata, modified;
  logic                           we, re;
  logic [AW-1:0]                  waddr, raddr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      req_q   <= rmfb_pkg::req_e'(in_user_i);
      x_q     <= in_data_i[11:0];
      y_q     <= in_data_i[23:12];
      black_q <= in_data_i[24];
      bidx_q  <= in_data_i[40:25];
    end
  end

  // clip against the logical size, then rotate into panel coordinates
  always_comb begin
    x_lo   = x_q[rmfb_pkg::CRD_W-1:0];
    y_lo   = y_q[rmfb_pkg::CRD_W-1:0];
    lw     = rotation_i[0] ? LH_ROT0 : LW_ROT0;
    lh     = rotation_i[0] ? LW_ROT0 : LH_ROT0;
    clip_d = x_q[rmfb_pkg::POS_W-1] || y_q[rmfb_pkg::POS_W-1] ||
             ({2'b00, x_lo} >= lw) || ({2'b00, y_lo} >= lh);
    case (rotation_i)
      rmfb_pkg::ROT_90: begin
        px_d = PW_M1 - y_lo;
        py_d = x_lo;
      end
      rmfb_pkg::ROT_180: begin
        px_d = PW_M1 - x_lo;
        py_d = PH_M1 - y_lo;
      end
      rmfb_pkg::ROT_270: begin
        px_d = y_lo;
        py_d = PH_M1 - x_lo;
      end
      default: begin
        px_d = x_lo;
        py_d = y_lo;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_step) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else if (cmd_i.map_step) begin
      clip_q <= clip_d;
    end
  end

  assign pix     = PIX_W'(py_q) * PW_PIX + PIX_W'(px_q);
  assign paddr_d = AW'(32'(pix[PIX_W-1:3]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_step) begin
      paddr_q <= paddr_d;
      bit_q   <= pix[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fill_q <= rmfb_pkg::FILL_WHITE;
    end else if (cmd_i.sweep_start) begin
      cnt_q  <= '0;
      fill_q <= black_q ? rmfb_pkg::FILL_BLACK : rmfb_pkg::FILL_WHITE;
    end else if (cmd_i.sweep_step) begin
      cnt_q <= (cnt_q == LAST_A) ? '0 : cnt_q + AW'(1);
    end
  end

  assign bidx_ext = 32'(bidx_q);
  assign bidx_a   = bidx_ext[AW-1:0];

  assign mask     = rmfb_pkg::MSB_MASK >> bit_q;
  assign modified = black_q ? (rdata & ~mask) : (rdata | mask);

  assign we    = cmd_i.sweep_step || cmd_i.wr_pixel;
  assign waddr = cmd_i.sweep_step ? cnt_q : paddr_q;
  assign wdata = cmd_i.sweep_step ? fill_q : modified;
  assign re    = cmd_i.rd_pixel || cmd_i.rd_byte;
  assign raddr = cmd_i.rd_byte ? bidx_a : paddr_q;

  rmfb_ram #(
    .WIDTH (rmfb_pkg::BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (cmd_i.res_kind)
        rmfb_pkg::RES_BYTE: begin
          rbyte_q <= rdata;
          rstat_q <= 1'b0;
        end
        rmfb_pkg::RES_FAIL: begin
          rbyte_q <= '0;
          rstat_q <= 1'b1;
        end
        default: begin
          rbyte_q <= '0;
          rstat_q <= 1'b0;
        end
      endcase
    end
  end

  assign stat_o.req        = req_q;
  assign stat_o.clipped    = clip_q;
  assign stat_o.rd_ok      = bidx_ext < 32'(STORE_BYTES);
  assign stat_o.sweep_last = (cnt_q == LAST_A);

  assign out_data_o = rbyte_q;
  assign out_user_o = rstat_q;

endmodule

`default_nettype wire

>>> hw/rtl/rotated_mono_framebuffer.sv
// One-bit-per-pixel frame store for a PANEL_WIDTH x PANEL_HEIGHT monochrome panel,
// (PANEL_WIDTH*PANEL_HEIGHT+7)/8 bytes in a single RAM, pixels packed MSB first.
// Each input beat is a pixel write (clipped against the rotated logical size),
// a clear of the whole store, a one-byte read or an unused request type; each
// gives exactly one output beat. One item is handled at a time and every access
// goes through the single RAM write port and registered read port: a pixel
// write is a read-modify-write, and a clear sweeps one byte a cycle. After reset
// the block fills the store with white, one byte a cycle, all STORE_BYTES bytes
// (48000 at the default size), with s_axis_tready low; the rotation register
// may be written at any time the block is idle.
`default_nettype none

module rotated_mono_framebuffer #(
  parameter int unsigned PANEL_WIDTH  = 800,
  parameter int unsigned PANEL_HEIGHT = 480
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pos_x[11:0], pos_y[23:12], is_black[24], byte_index[40:25], zero[47:41]
  input  wire logic [rmfb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type[1:0]
  input  wire logic [rmfb_pkg::IN_USER_W-1:0]      s_axis_tuser,

  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // read_byte[7:0]
  output logic      [rmfb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status[0]
  output logic      [rmfb_pkg::OUT_USER_W-1:0]     m_axis_tuser,

  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rmfb_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [rmfb_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [rmfb_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  logic [rmfb_pkg::ROT_W-1:0] rotation_q;
  logic                       reg_wr;
  rmfb_pkg::cmd_t             cmd;
  rmfb_pkg::stat_t            stat;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == rmfb_pkg::REG_ROTATION);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= rmfb_pkg::ROT_0;
    end else if (reg_wr) begin
      rotation_q <= pwdata[rmfb_pkg::ROT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == rmfb_pkg::REG_ROTATION) ?
                  rmfb_pkg::APB_DATA_W'(rotation_q) : '0;

  rmfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmfb_dpath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .rotation_i (rotation_q),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_rotated_mono_framebuffer.sv
`timescale 1ns / 1ps

module tb_rotated_mono_framebuffer;

  localparam int unsigned PANEL_W     = 800;
  localparam int unsigned PANEL_H     = 480;
  localparam int unsigned STORE_BYTES = (PANEL_W * PANEL_H + 7) / 8;
  localparam int unsigned IDLE_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam logic [rmfb_pkg::APB_ADDR_W-1:0] ROTATION_ADDR = {rmfb_pkg::REG_ROTATION, 2'b00};

  typedef struct packed {
    logic [rmfb_pkg::BYTE_W-1:0] read_byte;
    logic                        status;
  } beat_result_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rmfb_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [rmfb_pkg::IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [rmfb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [rmfb_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic                            psel          = 1'b0;
  logic                            penable       = 1'b0;
  logic                            pwrite        = 1'b0;
  logic [rmfb_pkg::APB_ADDR_W-1:0] paddr         = '0;
  logic [rmfb_pkg::APB_DATA_W-1:0] pwdata        = '0;
  logic [rmfb_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // shadow copy of the frame store and rotation register
  logic [rmfb_pkg::BYTE_W-1:0] panel_shadow [STORE_BYTES];
  logic [rmfb_pkg::ROT_W-1:0]  shadow_rot = rmfb_pkg::ROT_0;
  int unsigned       touched_bytes [$];
  beat_result_t      pending_results [$];
  int unsigned       n_fail      = 0;
  bit                quiet       = 1'b0;
  int unsigned       rx_hold_req = 0;
  int unsigned       idle_cycles = 0;

  rotated_mono_framebuffer #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic beat_result_t apply_panel_req(rmfb_pkg::req_e req,
      logic signed [rmfb_pkg::POS_W-1:0] x, logic signed [rmfb_pkg::POS_W-1:0] y,
      logic black, logic [rmfb_pkg::IDX_W-1:0] idx);
    beat_result_t                res;
    int                          lx;
    int                          ly;
    int                          lw;
    int                          lh;
    int                          px;
    int                          py;
    int                          bit_pos;
    int                          addr;
    logic [rmfb_pkg::BYTE_W-1:0] mask;
    res = '0;
    lx  = int'(x);
    ly  = int'(y);
    case (req)
      rmfb_pkg::REQ_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++)
          panel_shadow[i] = black ? rmfb_pkg::FILL_BLACK : rmfb_pkg::FILL_WHITE;
      end
      rmfb_pkg::REQ_READ: begin
        if (idx < STORE_BYTES) res.read_byte = panel_shadow[idx];
        else res.status = 1'b1;
      end
      rmfb_pkg::REQ_PIXEL: begin
        // odd quarter turns swap the logical size
        lw = shadow_rot[0] ? PANEL_H : PANEL_W;
        lh = shadow_rot[0] ? PANEL_W : PANEL_H;
        if (lx < 0 || lx >= lw || ly < 0 || ly >= lh) begin
          res.status = 1'b1;
        end else begin
          case (shadow_rot)
            rmfb_pkg::ROT_90: begin
              px = PANEL_W - 1 - ly;
              py = lx;
            end
            rmfb_pkg::ROT_180: begin
              px = PANEL_W - 1 - lx;
              py = PANEL_H - 1 - ly;
            end
            rmfb_pkg::ROT_270: begin
              px = ly;
              py = PANEL_H - 1 - lx;
            end
            default: begin
              px = lx;
              py = ly;
            end
          endcase
          bit_pos = py * PANEL_W + px;
          addr    = bit_pos / 8;
          mask    = rmfb_pkg::MSB_MASK >> (bit_pos % 8);
          if (black) panel_shadow[addr] = panel_shadow[addr] & ~mask;
          else panel_shadow[addr] = panel_shadow[addr] | mask;
          touched_bytes.push_back(addr);
          if (touched_bytes.size() > 16) void'(touched_bytes.pop_front());
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // coordinate inside [0, n), often on an edge
  function automatic logic signed [rmfb_pkg::POS_W-1:0] pick_coord(int n);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return rmfb_pkg::POS_W'(n - 1);
    return rmfb_pkg::POS_W'($urandom_range(0, n - 1));
  endfunction

  task automatic send_req(rmfb_pkg::req_e req, logic signed [rmfb_pkg::POS_W-1:0] x,
      logic signed [rmfb_pkg::POS_W-1:0] y, logic black, logic [rmfb_pkg::IDX_W-1:0] idx);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {7'b0, idx, black, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_panel_req(req, x, y, black, idx));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_rotation(logic [rmfb_pkg::ROT_W-1:0] rot);
    logic [rmfb_pkg::APB_DATA_W-1:0] want;
    want = {{(rmfb_pkg::APB_DATA_W - rmfb_pkg::ROT_W){1'b0}}, rot};
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROTATION_ADDR;
    pwdata  <= want;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_rot = rot;
    // read back, back to back with the write
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("rotation: expected %0h, actual %0h", want, prdata);
      n_fail++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned                       pick;
    int unsigned                       r;
    int                                lw;
    int                                lh;
    logic signed [rmfb_pkg::POS_W-1:0] x;
    logic signed [rmfb_pkg::POS_W-1:0] y;
    logic [rmfb_pkg::IDX_W-1:0]        idx;
    pick = $urandom_range(0, 99);
    lw   = shadow_rot[0] ? PANEL_H : PANEL_W;
    lh   = shadow_rot[0] ? PANEL_W : PANEL_H;
    x    = rmfb_pkg::POS_W'($urandom);
    y    = rmfb_pkg::POS_W'($urandom);
    idx  = rmfb_pkg::IDX_W'($urandom);
    if (pick < 58) begin
      if ($urandom_range(0, 4) != 0) begin
        x = pick_coord(lw);
        y = pick_coord(lh);
      end else begin
        // just outside the logical size, or anything at all
        case ($urandom_range(0, 4))
          0: begin x = '1;                      y = pick_coord(lh); end
          1: begin x = rmfb_pkg::POS_W'(lw);    y = pick_coord(lh); end
          2: begin x = pick_coord(lw);          y = '1;             end
          3: begin x = pick_coord(lw);          y = rmfb_pkg::POS_W'(lh); end
          default: ;
        endcase
      end
      send_req(rmfb_pkg::REQ_PIXEL, x, y, 1'($urandom_range(0, 1)), idx);
    end else if (pick < 95) begin
      r = $urandom_range(0, 9);
      if (r < 6 && touched_bytes.size() > 0)
        idx = rmfb_pkg::IDX_W'(touched_bytes[$urandom_range(0, touched_bytes.size() - 1)]);
      else if (r < 9) idx = rmfb_pkg::IDX_W'($urandom_range(0, STORE_BYTES - 1));
      else idx = rmfb_pkg::IDX_W'($urandom_range(STORE_BYTES, 16'hFFFF));
      send_req(rmfb_pkg::REQ_READ, x, y, 1'($urandom_range(0, 1)), idx);
    end else begin
      send_req(rmfb_pkg::REQ_NONE, x, y, 1'($urandom_range(0, 1)), idx);
    end
  endtask

  task automatic test_reset_state();
    send_req(rmfb_pkg::REQ_READ, '0, '0, 1'b0, '0);
    send_req(rmfb_pkg::REQ_READ, '0, '0, 1'b1, rmfb_pkg::IDX_W'(STORE_BYTES - 1));
    send_req(rmfb_pkg::REQ_READ, '0, '0, 1'b0, rmfb_pkg::IDX_W'(STORE_BYTES));
    send_req(rmfb_pkg::REQ_READ, '1, '1, 1'b1, 16'hFFFF);
    send_req(rmfb_pkg::REQ_NONE, 12'sh7FF, 12'sh800, 1'b1, 16'hFFFF);
  endtask

  task automatic test_pixels_and_clear();
    send_req(rmfb_pkg::REQ_PIXEL, '0, '0, 1'b1, '0);
    send_req(rmfb_pkg::REQ_PIXEL, rmfb_pkg::POS_W'(PANEL_W - 1), rmfb_pkg::POS_W'(PANEL_H - 1),
             1'b1, '0);
    send_req(rmfb_pkg::REQ_PIXEL, '1, '0, 1'b1, '0);
    send_req(rmfb_pkg::REQ_PIXEL, '0, '1, 1'b1, '0);
    send_req(rmfb_pkg::REQ_PIXEL, rmfb_pkg::POS_W'(PANEL_W), '0, 1'b1, '0);
    send_req(rmfb_pkg::REQ_PIXEL, '0, rmfb_pkg::POS_W'(PANEL_H), 1'b1, '0);
    send_req(rmfb_pkg::REQ_PIXEL, 12'sh7FF, 12'sh800, 1'b1, 16'hFFFF);
    send_req(rmfb_pkg::REQ_PIXEL, 12'sh800, 12'sh7FF, 1'b0, 16'hFFFF);
    send_req(rmfb_pkg::REQ_READ, '0, '0, 1'b0, '0);
    send_req(rmfb_pkg::REQ_READ, '0, '0, 1'b0, rmfb_pkg::IDX_W'(STORE_BYTES - 1));
    send_req(rmfb_pkg::REQ_PIXEL, '0, '0, 1'b0, '0);
    send_req(rmfb_pkg::REQ_READ, '0, '0, 1'b0, '0);
    send_req(rmfb_pkg::REQ_CLEAR, '0, '0, 1'b1, '0);
    send_req(rmfb_pkg::REQ_READ, '0, '0, 1'b0, rmfb_pkg::IDX_W'(STORE_BYTES / 2));
    send_req(rmfb_pkg::REQ_PIXEL, rmfb_pkg::POS_W'(5), '0, 1'b0, '0);
    send_req(rmfb_pkg::REQ_READ, '0, '0, 1'b0, '0);
    send_req(rmfb_pkg::REQ_CLEAR, 12'sh7FF, 12'sh7FF, 1'b0, 16'hFFFF);
    send_req(rmfb_pkg::REQ_READ, '0, '0, 1'b0, '0);
  endtask

  task automatic test_backpressure();
    rx_hold_req = HOLD_CYCLES;
    quiet       = 1'b1;
    repeat (12) send_random_item();
    quiet       = 1'b0;
  endtask

  task automatic test_random_rotations();
    logic [rmfb_pkg::ROT_W-1:0] rot_plan [6];
    int unsigned                clear_at;
    rot_plan = '{rmfb_pkg::ROT_90, rmfb_pkg::ROT_270, rmfb_pkg::ROT_180, rmfb_pkg::ROT_0,
                 rmfb_pkg::ROT_270, rmfb_pkg::ROT_90};
    for (int p = 0; p < 6; p++) begin
      set_rotation(rot_plan[p]);
      quiet    = (p == 3);
      clear_at = (p % 2 == 0) ? $urandom_range(20, 170) : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (clear_at != 0 && n == clear_at)
          send_req(rmfb_pkg::REQ_CLEAR, rmfb_pkg::POS_W'($urandom), rmfb_pkg::POS_W'($urandom),
                   1'($urandom_range(0, 1)), rmfb_pkg::IDX_W'($urandom));
        else send_random_item();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned  stall;
    beat_result_t want;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: read_byte %0h status %0b", m_axis_tdata, m_axis_tuser);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata !== want.read_byte) begin
            $error("read_byte: expected %0h, actual %0h", want.read_byte, m_axis_tdata);
            n_fail++;
          end
          if (m_axis_tuser[0] !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, m_axis_tuser[0]);
            n_fail++;
          end
        end
      end
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall == 0 && !quiet && $urandom_range(0, 99) < 12) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // no beat moves while a clear sweeps the whole store
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) panel_shadow[i] = rmfb_pkg::FILL_WHITE;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_pixels_and_clear();
    test_backpressure();
    test_random_rotations();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
